// ----- design/omc_pkg.sv -----
// Shared constants, register map and helpers for the orthogonal matrix check block.
package omc_pkg;

    localparam int ENTRY_BITS_DEF = 12;
    localparam int COEF_BITS_DEF  = 16;
    localparam int MOD_BITS       = 13;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;
    localparam int NUM_ENTRIES    = 9;

    localparam logic [2:0] REG_COEF_A = 3'd0;
    localparam logic [2:0] REG_COEF_B = 3'd1;
    localparam logic [2:0] REG_COEF_C = 3'd2;
    localparam logic [2:0] REG_MOD_M  = 3'd3;
    localparam logic [2:0] REG_MOD_N  = 3'd4;

    localparam logic [MOD_BITS-1:0] MOD_RST = 13'd8;

    function automatic int omc_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- design/omc_rem.sv -----
// Pipelined restoring remainder unit, one dividend bit per stage.
module omc_rem #(
    parameter int DW = 44,
    parameter int RW = 13
) (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic [DW-1:0]                 dividend,
    input  logic [omc_pkg::MOD_BITS-1:0]  divisor,
    output logic [RW-1:0]                 rem
);
    import omc_pkg::*;

    logic [RW-1:0] rem_reg [DW];
    logic [DW-1:0] num_reg [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [RW-1:0] r_in;
        logic [DW-1:0] n_in;
        logic [RW:0]   trial;
        logic [RW:0]   dext;
        logic [RW-1:0] rem_next;

        assign r_in  = (k == 0) ? '0 : rem_reg[(k == 0) ? 0 : k-1];
        assign n_in  = (k == 0) ? dividend : num_reg[(k == 0) ? 0 : k-1];
        assign trial = {r_in, n_in[DW-1]};
        assign dext  = (RW+1)'(divisor);

        // A zero divisor never subtracts, so the low bits pass through.
        always_comb begin
            if ((divisor != '0) && (trial >= dext)) begin
                rem_next = RW'(trial - dext);
            end else begin
                rem_next = trial[RW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= n_in << 1;
            end
        end
    end

    assign rem = rem_reg[DW-1];

endmodule

// ----- design/omc_form_lane.sv -----
// One bilinear form lane: products, coefficient scaling, sum and divisibility test.
module omc_form_lane #(
    parameter int ENTRY_BITS = 12,
    parameter int COEF_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic [2:0][ENTRY_BITS-1:0]    u,
    input  logic [2:0][ENTRY_BITS-1:0]    v,
    input  logic signed [COEF_BITS-1:0]   ca,
    input  logic signed [COEF_BITS-1:0]   cb,
    input  logic signed [COEF_BITS-1:0]   cc,
    input  logic signed [COEF_BITS-1:0]   sub,
    input  logic [omc_pkg::MOD_BITS-1:0]  divisor,
    output logic                          zero
);
    import omc_pkg::*;

    localparam int PW = 2*ENTRY_BITS;
    localparam int TW = COEF_BITS + PW + 1;
    localparam int VW = omc_max(COEF_BITS + 2*ENTRY_BITS + 4, 3*ENTRY_BITS + 5);
    localparam int RW = omc_max(MOD_BITS, ENTRY_BITS);

    logic [PW-1:0]        prod_reg [3];
    logic signed [TW-1:0] term_reg [3];
    logic [VW-1:0]        mag_reg;
    logic signed [VW-1:0] sum;
    logic signed [COEF_BITS-1:0] coef [3];
    logic [RW-1:0]        rem;

    assign coef[0] = ca;
    assign coef[1] = cb;
    assign coef[2] = cc;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= PW'(u[i]) * PW'(v[i]);
                term_reg[i] <= TW'(coef[i]) * TW'($signed({1'b0, prod_reg[i]}));
            end
            mag_reg <= sum[VW-1] ? VW'(-sum) : VW'(sum);
        end
    end

    assign sum = VW'(term_reg[0]) + VW'(term_reg[1]) + VW'(term_reg[2]) - VW'(sub);

    omc_rem #(.DW(VW), .RW(RW)) u_rem (
        .aclk     (aclk),
        .adv      (adv),
        .dividend (mag_reg),
        .divisor  (divisor),
        .rem      (rem)
    );

    assign zero = (rem == '0);

endmodule

// ----- design/omc_det_lane.sv -----
// Determinant lane: cofactor minors, expansion along the first row and test of det - 1.
module omc_det_lane #(
    parameter int ENTRY_BITS = 12,
    parameter int COEF_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic [2:0][ENTRY_BITS-1:0]    col0,
    input  logic [2:0][ENTRY_BITS-1:0]    col1,
    input  logic [2:0][ENTRY_BITS-1:0]    col2,
    input  logic [omc_pkg::MOD_BITS-1:0]  divisor,
    output logic                          zero
);
    import omc_pkg::*;

    localparam int E  = ENTRY_BITS;
    localparam int NW = 2*E + 1;
    localparam int TW = 3*E + 2;
    localparam int VW = omc_max(COEF_BITS + 2*E + 4, 3*E + 5);
    localparam int RW = omc_max(MOD_BITS, E);

    logic signed [NW-1:0] minor_reg [3];
    logic [E-1:0]         top_reg [3];
    logic signed [TW-1:0] term_reg [3];
    logic [VW-1:0]        mag_reg;
    logic signed [VW-1:0] sum;
    logic [RW-1:0]        rem;

    function automatic logic signed [NW-1:0] minor2(input logic [E-1:0] a, input logic [E-1:0] b,
                                                    input logic [E-1:0] c, input logic [E-1:0] d);
        return $signed(NW'(a) * NW'(b)) - $signed(NW'(c) * NW'(d));
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            minor_reg[0] <= minor2(col1[1], col2[2], col1[2], col2[1]);
            minor_reg[1] <= minor2(col0[1], col2[2], col0[2], col2[1]);
            minor_reg[2] <= minor2(col0[1], col1[2], col0[2], col1[1]);
            top_reg[0]   <= col0[0];
            top_reg[1]   <= col1[0];
            top_reg[2]   <= col2[0];
            for (int i = 0; i < 3; i++) begin
                term_reg[i] <= TW'($signed({1'b0, top_reg[i]})) * TW'(minor_reg[i]);
            end
            mag_reg <= sum[VW-1] ? VW'(-sum) : VW'(sum);
        end
    end

    assign sum = VW'(term_reg[0]) - VW'(term_reg[1]) + VW'(term_reg[2]) - VW'(1);

    omc_rem #(.DW(VW), .RW(RW)) u_rem (
        .aclk     (aclk),
        .adv      (adv),
        .dividend (mag_reg),
        .divisor  (divisor),
        .rem      (rem)
    );

    assign zero = (rem == '0);

endmodule

// ----- design/orthogonal_matrix_mod_check.sv -----
// Top level of the orthogonal matrix check: register file, lanes, merge and output stage.
//
//  channel   dir   handshake          payload
//  s_        in    tvalid/tready      tdata: 9 entries, c0_x .. c2_z
//  m_        out   tvalid/tready      tdata: hit, r0_x .. r2_z
//  apb       in    psel/penable/...   coef_a, coef_b, coef_c, modulus_m, modulus_n
//
// One request is taken every cycle while the output side keeps up. Each lane has
// registered product, term and magnitude steps (delay registers for the entries)
// ahead of its bit-serial remainder pipeline. The reset is synchronous and active
// low; it clears the valid chain and loads the register defaults. When m_tready is
// low with a result waiting, the whole pipeline holds and s_tready drops in the
// same cycle.
module orthogonal_matrix_mod_check #(
    parameter int ENTRY_BITS = omc_pkg::ENTRY_BITS_DEF,
    parameter int COEF_BITS  = omc_pkg::COEF_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // fields from bit 0 up: c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z
    input  logic [((9*ENTRY_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // fields from bit 0 up: hit, r0_x, r0_y, r0_z, r1_x, r1_y, r1_z, r2_x, r2_y, r2_z
    output logic [((9*ENTRY_BITS+8)/8)*8-1:0]       m_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [omc_pkg::APB_AW-1:0]              paddr,
    input  logic [omc_pkg::APB_DW-1:0]              pwdata,
    output logic [omc_pkg::APB_DW-1:0]              prdata,
    output logic                                    pready
);
    import omc_pkg::*;

    localparam int E  = ENTRY_BITS;
    localparam int VW = omc_max(COEF_BITS + 2*E + 4, 3*E + 5);
    localparam int RW = omc_max(MOD_BITS, E);
    localparam int LAT = 3 + VW;

    // Configuration registers.
    logic signed [COEF_BITS-1:0] coef_a_reg, coef_b_reg, coef_c_reg;
    logic [MOD_BITS-1:0]         mod_m_reg, mod_n_reg;
    logic                        wr_en;
    logic [2:0]                  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg <= COEF_BITS'(1);
            coef_b_reg <= COEF_BITS'(1);
            coef_c_reg <= COEF_BITS'(1);
            mod_m_reg  <= MOD_RST;
            mod_n_reg  <= MOD_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_COEF_A: coef_a_reg <= $signed(pwdata[COEF_BITS-1:0]);
                REG_COEF_B: coef_b_reg <= $signed(pwdata[COEF_BITS-1:0]);
                REG_COEF_C: coef_c_reg <= $signed(pwdata[COEF_BITS-1:0]);
                REG_MOD_M:  mod_m_reg  <= pwdata[MOD_BITS-1:0];
                REG_MOD_N:  mod_n_reg  <= pwdata[MOD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COEF_A: prdata = APB_DW'(coef_a_reg);
            REG_COEF_B: prdata = APB_DW'(coef_b_reg);
            REG_COEF_C: prdata = APB_DW'(coef_c_reg);
            REG_MOD_M:  prdata = APB_DW'(mod_m_reg);
            REG_MOD_N:  prdata = APB_DW'(mod_n_reg);
            default:    prdata = '0;
        endcase
    end

    // The pipeline moves as one whenever the output slot is free or being drained.
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Unpack the columns.
    logic [2:0][E-1:0] col [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                col[r][c] = s_tdata[(r*3+c)*E +: E];
            end
        end
    end

    // Six form lanes: three norms against their coefficient, three column pairs against zero.
    logic [6:0] lane_zero;
    logic signed [COEF_BITS-1:0] norm_sub [3];

    assign norm_sub[0] = coef_a_reg;
    assign norm_sub[1] = coef_b_reg;
    assign norm_sub[2] = coef_c_reg;

    for (genvar r = 0; r < 3; r++) begin : g_norm
        omc_form_lane #(.ENTRY_BITS(E), .COEF_BITS(COEF_BITS)) u_lane (
            .aclk    (aclk),
            .adv     (adv),
            .u       (col[r]),
            .v       (col[r]),
            .ca      (coef_a_reg),
            .cb      (coef_b_reg),
            .cc      (coef_c_reg),
            .sub     (norm_sub[r]),
            .divisor (mod_m_reg),
            .zero    (lane_zero[r])
        );
    end

    for (genvar p = 0; p < 3; p++) begin : g_pair
        // Pairs (0,1), (0,2), (1,2).
        localparam int PA = (p == 2) ? 1 : 0;
        localparam int PB = (p == 0) ? 1 : 2;
        omc_form_lane #(.ENTRY_BITS(E), .COEF_BITS(COEF_BITS)) u_lane (
            .aclk    (aclk),
            .adv     (adv),
            .u       (col[PA]),
            .v       (col[PB]),
            .ca      (coef_a_reg),
            .cb      (coef_b_reg),
            .cc      (coef_c_reg),
            .sub     ('0),
            .divisor (mod_m_reg),
            .zero    (lane_zero[3+p])
        );
    end

    omc_det_lane #(.ENTRY_BITS(E), .COEF_BITS(COEF_BITS)) u_det (
        .aclk    (aclk),
        .adv     (adv),
        .col0    (col[0]),
        .col1    (col[1]),
        .col2    (col[2]),
        .divisor (mod_m_reg),
        .zero    (lane_zero[6])
    );

    // Entry lanes: delay registers that line up with the product, term and magnitude stages,
    // then the same remainder pipeline against modulus_n.
    logic [E-1:0]  ent_dly_reg [3][NUM_ENTRIES];
    logic [RW-1:0] ent_rem [NUM_ENTRIES];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                ent_dly_reg[0][i] <= s_tdata[i*E +: E];
                ent_dly_reg[1][i] <= ent_dly_reg[0][i];
                ent_dly_reg[2][i] <= ent_dly_reg[1][i];
            end
        end
    end

    for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_ent
        omc_rem #(.DW(VW), .RW(RW)) u_rem (
            .aclk     (aclk),
            .adv      (adv),
            .dividend (VW'(ent_dly_reg[2][i])),
            .divisor  (mod_n_reg),
            .rem      (ent_rem[i])
        );
    end

    // Merge: a zero modulus_m never gives a hit.
    logic hit;

    assign hit = (mod_m_reg != '0) && (&lane_zero);

    always_comb begin
        m_tdata    = '0;
        m_tdata[0] = hit;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            m_tdata[1+i*E +: E] = ent_rem[i][E-1:0];
        end
    end

endmodule

// ----- design/omc_checker.sv -----
// Port-level checks of the orthogonal matrix check block, bound to its top level.
module omc_checker #(
    parameter int ENTRY_BITS = omc_pkg::ENTRY_BITS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((9*ENTRY_BITS+8)/8)*8-1:0]   m_tdata
);
    import omc_pkg::*;

    // A held result stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The input side only stalls when a result is waiting on a stalled sink.
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

endmodule

bind orthogonal_matrix_mod_check omc_checker #(.ENTRY_BITS(ENTRY_BITS)) u_omc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the orthogonal matrix congruence checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import omc_pkg::*;

    localparam int EB = ENTRY_BITS_DEF;
    localparam int SW = ((9*EB+7)/8)*8;
    localparam int MW = ((9*EB+8)/8)*8;
    localparam int RAW_ITEMS = 800;

    typedef logic [EB-1:0] entry_t;

    // One expected result: the hit flag and the nine reduced entries.
    typedef struct {
        logic   hit;
        entry_t ent [9];
    } verdict_t;

    // Scoreboard: holds the current register settings, predicts the verdict of each
    // accepted request and compares each accepted result with the oldest prediction.
    class matrix_scoreboard;
        longint coef [3];
        longint mod_m;
        longint mod_n;
        verdict_t pending [$];
        int errors;

        function new();
            coef[0] = 1; coef[1] = 1; coef[2] = 1;
            mod_m = 8; mod_n = 8; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_COEF_A: coef[0] = longint'($signed(val[15:0]));
                REG_COEF_B: coef[1] = longint'($signed(val[15:0]));
                REG_COEF_C: coef[2] = longint'($signed(val[15:0]));
                REG_MOD_M:  mod_m = longint'(val[12:0]);
                REG_MOD_N:  mod_n = longint'(val[12:0]);
                default: ;
            endcase
        endfunction

        // True non-negative residue is zero exactly when m divides v.
        function bit divides(longint v, longint m);
            return (v % m) == 0;
        endfunction

        function longint form(longint u [3], longint v [3]);
            return coef[0]*u[0]*v[0] + coef[1]*u[1]*v[1] + coef[2]*u[2]*v[2];
        endfunction

        function void note_request(logic [SW-1:0] d);
            verdict_t vd;
            longint col [3][3];
            longint det;
            bit ok;
            for (int i = 0; i < 9; i++) col[i/3][i%3] = longint'(d[i*EB +: EB]);
            ok = 0;
            if (mod_m != 0) begin
                ok = 1;
                for (int r = 0; r < 3; r++)
                    if (!divides(form(col[r], col[r]) - coef[r], mod_m)) ok = 0;
                if (!divides(form(col[0], col[1]), mod_m)) ok = 0;
                if (!divides(form(col[0], col[2]), mod_m)) ok = 0;
                if (!divides(form(col[1], col[2]), mod_m)) ok = 0;
                det = col[0][0]*(col[1][1]*col[2][2] - col[1][2]*col[2][1])
                    - col[1][0]*(col[0][1]*col[2][2] - col[0][2]*col[2][1])
                    + col[2][0]*(col[0][1]*col[1][2] - col[0][2]*col[1][1]);
                if (!divides(det - 1, mod_m)) ok = 0;
            end
            vd.hit = ok;
            for (int i = 0; i < 9; i++)
                vd.ent[i] = entry_t'((mod_n != 0) ? col[i/3][i%3] % mod_n : col[i/3][i%3]);
            pending.insert(pending.size(), vd);
        endfunction

        function void check_result(logic [MW-1:0] d);
            verdict_t vd;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, d);
                errors++;
                return;
            end
            vd = pending.pop_front();
            if (d[0] !== vd.hit) begin
                $display("%0t: hit expected %0b actual %0b", $realtime, vd.hit, d[0]);
                errors++;
            end
            for (int i = 0; i < 9; i++)
                if (d[1 + i*EB +: EB] !== vd.ent[i]) begin
                    $display("%0t: entry %0d expected %0d actual %0d",
                             $realtime, i, vd.ent[i], d[1 + i*EB +: EB]);
                    errors++;
                end
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic [SW-1:0] s_tdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [MW-1:0] m_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic          psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic          pready;

    matrix_scoreboard board = new();

    // Random gaps on both sides, switched off for a stretch in the middle of the run.
    bit calm;
    // Set while the receiver deliberately holds off to back the pipeline up.
    bit backpressure;

    orthogonal_matrix_mod_check DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Register write in setup and access phases; the scoreboard follows once access is taken.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= APB_AW'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_reg(idx, val);
    endtask

    // Offers one request, with an occasional idle gap first, and waits for acceptance.
    // Valid stays high between back-to-back requests; only a gap or settle() lowers it.
    task automatic send_matrix(entry_t e [9]);
        logic [SW-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*EB +: EB] = e[i];
        if (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_request(d);
    endtask

    task automatic send_vals(int a0, int a1, int a2, int a3, int a4, int a5,
                             int a6, int a7, int a8);
        entry_t e [9];
        e[0] = entry_t'(a0); e[1] = entry_t'(a1); e[2] = entry_t'(a2);
        e[3] = entry_t'(a3); e[4] = entry_t'(a4); e[5] = entry_t'(a5);
        e[6] = entry_t'(a6); e[7] = entry_t'(a7); e[8] = entry_t'(a8);
        send_matrix(e);
    endtask

    // Waits until every prediction has been matched, then lets the pipeline drain.
    task automatic settle();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // Random matrix: mostly small signed permutation matrices, which pass or nearly pass
    // the congruences, with the remainder random entries below the modulus or full-range noise.
    task automatic send_random(int mm);
        entry_t e [9];
        int p, sel;
        sel = $urandom_range(99);
        if (sel < 60) begin
            p = $urandom_range(5);
            for (int i = 0; i < 9; i++) e[i] = '0;
            for (int c = 0; c < 3; c++) begin
                int row;
                row = (c + p) % 3;
                if (p >= 3) row = (3 - c + p) % 3;
                e[c*3 + row] = ($urandom_range(1) && mm > 1) ? entry_t'(mm - 1) : entry_t'(1);
            end
            if ($urandom_range(4) == 0)
                e[$urandom_range(8)] = entry_t'($urandom_range(mm > 0 ? mm-1 : 0));
        end else if (sel < 80) begin
            for (int i = 0; i < 9; i++) e[i] = entry_t'($urandom_range(mm > 0 ? mm - 1 : 4095));
        end else begin
            for (int i = 0; i < 9; i++) e[i] = entry_t'($urandom());
        end
        send_matrix(e);
    endtask

    // Receiver: random stalls, plus one long hold-off counted here so the block fills up.
    initial begin
        int held;
        held = 0;
        m_tready <= 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            if (backpressure && held < 200) begin
                m_tready <= 0;
                held++;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    initial begin
        #20ms;
        $display("FAIL orthogonal_matrix_mod_check");
        $finish;
    end

    initial begin
        int mods [6];
        aresetn <= 0;
        s_tvalid <= 0; s_tdata <= '0;
        psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
        calm = 0; backpressure = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset settings (identity form mod 8), then the corner settings.
        send_vals(1,0,0, 0,1,0, 0,0,1);
        send_vals(0,1,0, 1,0,0, 0,0,1);
        send_vals(7,0,0, 0,7,0, 0,0,1);
        send_vals(4095,4095,4095, 4095,4095,4095, 4095,4095,4095);
        send_vals(0,0,0, 0,0,0, 0,0,0);
        send_vals(9,0,0, 0,9,0, 0,0,9);
        settle();
        write_reg(REG_COEF_A, 32'h0000_8000);
        write_reg(REG_COEF_B, 32'h0000_7FFF);
        write_reg(REG_COEF_C, 32'hFFFF_FFFF);
        write_reg(REG_MOD_M, 32'd4096);
        write_reg(REG_MOD_N, 32'd4096);
        send_vals(4095,4095,4095, 4095,4095,4095, 4095,4095,4095);
        send_vals(1,0,0, 0,1,0, 0,0,1);
        send_vals(4095,0,0, 0,4095,0, 0,0,4095);
        settle();
        // Zero moduli: hit must be clear and entries pass through unreduced.
        write_reg(REG_MOD_M, 32'd0);
        write_reg(REG_MOD_N, 32'd0);
        send_vals(1,0,0, 0,1,0, 0,0,1);
        send_vals(4095,2730,1365, 4095,2730,1365, 4095,2730,1365);
        settle();
        // Modulus one: every congruence holds.
        write_reg(REG_MOD_M, 32'd1);
        write_reg(REG_MOD_N, 32'd1);
        send_vals(123,4095,7, 0,1,2, 3,4,5);
        send_vals(4095,4095,4095, 4095,4095,4095, 4095,4095,4095);
        settle();

        // Random phases over several settings.
        mods = '{8, 4096, 1, 0, 13, 2};
        for (int ph = 0; ph < 8; ph++) begin
            int mm;
            mm = mods[ph % 6];
            if (ph == 0) begin
                write_reg(REG_COEF_A, 32'd1); write_reg(REG_COEF_B, 32'd1);
                write_reg(REG_COEF_C, 32'd1);
            end else begin
                write_reg(REG_COEF_A, $urandom_range(1) ? 32'd1 : $urandom());
                write_reg(REG_COEF_B, $urandom_range(1) ? 32'd1 : $urandom());
                write_reg(REG_COEF_C, $urandom_range(1) ? 32'hFFFF : $urandom());
            end
            write_reg(REG_MOD_M, mm);
            write_reg(REG_MOD_N, $urandom_range(1) ? mm : $urandom_range(4096));
            calm = (ph == 3);
            backpressure = (ph == 1);
            for (int k = 0; k < RAW_ITEMS / 8; k++) send_random(mm);
            backpressure = 0;
            settle();
        end
        calm = 0;

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS orthogonal_matrix_mod_check");
        else
            $display("FAIL orthogonal_matrix_mod_check");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/omc_pkg.sv
design/omc_rem.sv
design/omc_form_lane.sv
design/omc_det_lane.sv
design/orthogonal_matrix_mod_check.sv
design/omc_checker.sv
verif/testbench.sv
